[design/qbbs_pkg.sv]
`default_nettype none
package qbbs_pkg;

  localparam int MAX_BANDS_DEF = 64;

  localparam int COORD_W   = 16;
  localparam int BAND_W    = 6;
  localparam int CNT_W     = 7;
  localparam int HGT_W     = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOP_Y       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_HEIGHT = 2'd2;

  localparam logic signed [COORD_W-1:0] TOP_Y_RST       = 16'sd0;
  localparam logic [CNT_W-1:0]          BAND_COUNT_RST  = 7'd1;
  localparam logic [HGT_W-1:0]          BAND_HEIGHT_RST = 15'd75;

  // t is Q0.16 with 1.0 encoded as 65536
  localparam int              T_W   = 17;
  localparam logic [T_W-1:0]  T_ONE = 17'h10000;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t            sx;
    coord_t            sy;
    coord_t            cx;
    coord_t            cy;
    coord_t            ex;
    coord_t            ey;
    logic [BAND_W-1:0] band;
    logic              last;
  } piece_t;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_BLOAD  = 12'b0000_0000_0010,
    S_DECIDE = 12'b0000_0000_0100,
    S_EDGE   = 12'b0000_0000_1000,
    S_COEF   = 12'b0000_0001_0000,
    S_BB     = 12'b0000_0010_0000,
    S_AC     = 12'b0000_0100_0000,
    S_SQRT   = 12'b0000_1000_0000,
    S_NORM   = 12'b0001_0000_0000,
    S_DIV    = 12'b0010_0000_0000,
    S_INTERP = 12'b0100_0000_0000,
    S_EMIT   = 12'b1000_0000_0000
  } state_t;

endpackage
`default_nettype wire

[design/qbbs_if.sv]
`default_nettype none
interface qbbs_in_if import qbbs_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t ctrl_x;
  coord_t ctrl_y;
  coord_t end_x;
  coord_t end_y;
  modport source (output valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
                  input ready);
  modport sink (input valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
                output ready);
endinterface

interface qbbs_out_if import qbbs_pkg::*; ();
  logic              valid;
  logic              ready;
  coord_t            piece_start_x;
  coord_t            piece_start_y;
  coord_t            piece_ctrl_x;
  coord_t            piece_ctrl_y;
  coord_t            piece_end_x;
  coord_t            piece_end_y;
  logic [BAND_W-1:0] band_index;
  logic              last_piece;
  modport source (output valid, piece_start_x, piece_start_y, piece_ctrl_x, piece_ctrl_y,
                  piece_end_x, piece_end_y, band_index, last_piece, input ready);
  modport sink (input valid, piece_start_x, piece_start_y, piece_ctrl_x, piece_ctrl_y,
                piece_end_x, piece_end_y, band_index, last_piece, output ready);
endinterface

interface qbbs_cfg_if import qbbs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/quadratic_bezier_band_splitter.sv]
// A segment inside one band gives its item after two band divisions on the shared divider;
//   each further band crossed adds an edge solve (square root unless straight in y, then a
//   divide) and the multiply steps of the split.
// One segment at a time: in_ch.ready is high only while idle.
// The next segment may be accepted while the last piece still waits in the output register.
// Reset (rst_n low, synchronous): config back to top_y=0, band_count=1, band_height=75.
`default_nettype none
module quadratic_bezier_band_splitter import qbbs_pkg::*; #(
  parameter int MAX_BANDS = MAX_BANDS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  qbbs_cfg_if.sink   cfg_ch,
  qbbs_in_if.sink    in_ch,
  qbbs_out_if.source out_ch
);

  localparam int DIV_N_W = 44;  // dividend width after scaling by 2^16
  localparam int DIV_D_W = 19;  // divisor magnitude width
  localparam int DIV_Q_W = 18;  // quotient bits produced
  localparam int SQ_W    = 48;  // discriminant width
  localparam int SQ_STEPS = SQ_W / 2;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  coord_t           top_y_r;
  logic [CNT_W-1:0] band_count_r;
  logic [HGT_W-1:0] band_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_y_r       <= TOP_Y_RST;
      band_count_r  <= BAND_COUNT_RST;
      band_height_r <= BAND_HEIGHT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_TOP_Y:       top_y_r       <= coord_t'(cfg_ch.data);
        REG_BAND_COUNT:  band_count_r  <= cfg_ch.data[CNT_W-1:0];
        REG_BAND_HEIGHT: band_height_r <= cfg_ch.data[HGT_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // effective count saturated to 1..MAX_BANDS, zero height taken as 1
  logic [CNT_W-1:0]  cnt_eff;
  logic [BAND_W-1:0] band_max;
  logic [HGT_W-1:0]  h_eff;

  always_comb begin
    if (band_count_r == '0) cnt_eff = CNT_W'(1);
    else if (band_count_r > CNT_W'(MAX_BANDS)) cnt_eff = CNT_W'(MAX_BANDS);
    else cnt_eff = band_count_r;
    band_max = BAND_W'(cnt_eff - CNT_W'(1));
    h_eff    = (band_height_r == '0) ? HGT_W'(1) : band_height_r;
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and working registers
  // ---------------------------------------------------------------------------
  state_t state_r;

  coord_t p_r [6];       // remaining piece: x0 y0 x1 y1 x2 y2
  piece_t pc_r;          // piece staged for output
  piece_t out_r;
  logic   out_valid_r;

  logic              band_sel_r;   // 0: top band lookup, 1: bottom band lookup
  logic [BAND_W-1:0] btop_r;
  logic [BAND_W-1:0] bbot_r;
  logic [BAND_W-1:0] cur_band_r;
  logic [BAND_W-1:0] end_band_r;
  logic              asc_r;        // end point lies above start point

  logic signed [23:0] edge_r;      // y of the band edge being cut
  logic signed [17:0] a_r;
  logic signed [17:0] b_r;
  logic signed [24:0] c_r;
  logic               s_r;
  logic signed [SQ_W-1:0] d_r;

  logic [SQ_W-1:0] sq_v_r;
  logic [SQ_W-1:0] sq_root_r;
  logic [SQ_W-1:0] sq_bit_r;
  logic [4:0]      cnt_r;

  logic signed [DIV_N_W-1:0] num_r;
  logic signed [19:0]        den_r;

  logic [DIV_D_W-1:0] dv_den_r;
  logic [DIV_D_W-1:0] dv_rem_r;
  logic [DIV_Q_W-1:0] dv_low_r;
  logic [DIV_Q_W-1:0] dv_q_r;
  logic               dv_band_r;   // divider serves a band lookup

  logic [T_W-1:0] t_r;
  logic           axis_r;          // 0: x, 1: y
  logic [2:0]     j_r;             // interpolation step within an axis
  logic signed [51:0] acc_r;
  logic signed [33:0] q0_r;
  logic signed [33:0] q1_r;
  logic signed [51:0] m_r;

  // ---------------------------------------------------------------------------
  // Rounding helpers, half away from zero
  // ---------------------------------------------------------------------------
  function automatic coord_t rnd_q16(input logic signed [33:0] v);
    logic [34:0] mag;
    logic [34:0] r;
    mag = v[33] ? 35'(-(35'(v))) : 35'(v);
    r   = (mag + 35'(32768)) >> 16;
    return v[33] ? coord_t'(-r[15:0]) : coord_t'(r[15:0]);
  endfunction

  function automatic coord_t rnd_q32(input logic signed [51:0] v);
    logic [52:0] mag;
    logic [52:0] r;
    mag = v[51] ? 53'(-(53'(v))) : 53'(v);
    r   = (mag + (53'(1) << 31)) >> 32;
    return v[51] ? coord_t'(-r[15:0]) : coord_t'(r[15:0]);
  endfunction

  // ---------------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------------
  coord_t y0, y2, ymax, ymin;
  assign y0   = p_r[1];
  assign y2   = p_r[5];
  assign ymax = (y2 > y0) ? y2 : y0;
  assign ymin = (y2 < y0) ? y2 : y0;

  // quadratic coefficients of the remaining piece against the edge
  logic signed [17:0] coef_a, coef_b;
  logic signed [24:0] coef_c;
  logic signed [19:0] lin_den;
  logic signed [DIV_N_W-1:0] lin_num;

  always_comb begin
    coef_a  = 18'(p_r[1]) - (18'(p_r[3]) <<< 1) + 18'(p_r[5]);
    coef_b  = (18'(p_r[3]) - 18'(p_r[1])) <<< 1;
    coef_c  = 25'(p_r[1]) - 25'(edge_r);
    lin_den = 20'(p_r[5]) - 20'(p_r[1]);
    lin_num = (DIV_N_W'(edge_r) - DIV_N_W'(p_r[1])) <<< 16;
  end

  // shared multiplier
  logic [T_W-1:0]     u_w;
  logic [2:0]         idx0, idx1, idx2;
  logic [CNT_W-1:0]   k_w;
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] mul_p;

  assign u_w  = T_ONE - t_r;
  assign idx0 = {2'b00, axis_r};
  assign idx1 = {2'b01, axis_r};
  assign idx2 = {2'b10, axis_r};
  assign k_w  = asc_r ? CNT_W'(cur_band_r) : CNT_W'(cur_band_r) + CNT_W'(1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_EDGE: begin
        mul_a = $signed({19'b0, h_eff});
        mul_b = $signed({11'b0, k_w});
      end
      S_BB: begin
        mul_a = 34'(b_r);
        mul_b = b_r;
      end
      S_AC: begin
        mul_a = 34'(c_r);
        mul_b = a_r;
      end
      S_INTERP: begin
        case (j_r)
          3'd0: begin mul_a = 34'(p_r[idx0]); mul_b = $signed({1'b0, u_w}); end
          3'd1: begin mul_a = 34'(p_r[idx1]); mul_b = $signed({1'b0, t_r}); end
          3'd2: begin mul_a = 34'(p_r[idx1]); mul_b = $signed({1'b0, u_w}); end
          3'd3: begin mul_a = 34'(p_r[idx2]); mul_b = $signed({1'b0, t_r}); end
          3'd4: begin mul_a = q0_r;           mul_b = $signed({1'b0, u_w}); end
          3'd5: begin mul_a = q1_r;           mul_b = $signed({1'b0, t_r}); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // band lookup dividend: top_y - y, negative gives band 0
  logic signed [16:0] band_a;
  assign band_a = 17'(top_y_r) - 17'(band_sel_r ? ymin : ymax);

  // discriminant after the a*c product
  logic signed [SQ_W-1:0] disc_w;
  assign disc_w = d_r - (SQ_W'(mul_p) <<< 2);

  // square root step
  logic [SQ_W-1:0] sq_try;
  assign sq_try = sq_root_r + sq_bit_r;

  // root applied with the direction sign
  logic signed [25:0] root_s, root_sum;
  assign root_s   = s_r ? 26'(sq_root_r[23:0]) : -26'(sq_root_r[23:0]);
  assign root_sum = root_s - 26'(b_r);

  // sign normalization of the t division
  logic signed [19:0]        den_fix;
  logic signed [DIV_N_W-1:0] num_fix;
  logic [DIV_D_W-1:0]        den_abs;
  logic [DIV_N_W-1:0]        num_rnd;
  assign den_fix = den_r[19] ? -den_r : den_r;
  assign num_fix = den_r[19] ? -num_r : num_r;
  assign den_abs = den_fix[DIV_D_W-1:0];
  assign num_rnd = DIV_N_W'(num_fix) + DIV_N_W'(den_abs >> 1);

  // divider load and step
  logic [DIV_N_W-1:0] dv_n;
  logic [DIV_D_W-1:0] dv_d;
  logic [DIV_N_W-DIV_Q_W-1:0] dv_hi;
  logic               dv_sat;
  logic [DIV_D_W:0]   dv_trial;
  logic               dv_ge;

  always_comb begin
    if (state_r == S_BLOAD) begin
      dv_n = band_a[16] ? '0 : DIV_N_W'(band_a[15:0]);
      dv_d = DIV_D_W'(h_eff);
    end else begin
      dv_n = num_rnd;
      dv_d = den_abs;
    end
    dv_hi    = dv_n[DIV_N_W-1:DIV_Q_W];
    dv_sat   = dv_hi >= (DIV_N_W-DIV_Q_W)'(dv_d);
    dv_trial = {dv_rem_r, dv_low_r[DIV_Q_W-1]};
    dv_ge    = dv_trial >= {1'b0, dv_den_r};
  end

  logic [BAND_W-1:0] band_q;
  assign band_q = (dv_q_r > DIV_Q_W'(band_max)) ? band_max : dv_q_r[BAND_W-1:0];

  logic [BAND_W-1:0] next_band;
  assign next_band = asc_r ? cur_band_r - BAND_W'(1) : cur_band_r + BAND_W'(1);

  logic out_load;
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            p_r[0] <= in_ch.start_x;
            p_r[1] <= in_ch.start_y;
            p_r[2] <= in_ch.ctrl_x;
            p_r[3] <= in_ch.ctrl_y;
            p_r[4] <= in_ch.end_x;
            p_r[5] <= in_ch.end_y;
            band_sel_r <= 1'b0;
            state_r <= S_BLOAD;
          end
        end

        // band of the higher, then the lower end point
        S_BLOAD: begin
          dv_band_r <= 1'b1;
          dv_den_r  <= dv_d;
          dv_rem_r  <= dv_hi[DIV_D_W-1:0];
          dv_low_r  <= dv_n[DIV_Q_W-1:0];
          dv_q_r    <= '0;
          cnt_r     <= 5'(DIV_Q_W);
          state_r   <= S_DIV;
        end

        S_DECIDE: begin
          asc_r      <= y2 > y0;
          cur_band_r <= (y2 > y0) ? bbot_r : btop_r;
          end_band_r <= (y2 > y0) ? btop_r : bbot_r;
          if (btop_r == bbot_r) begin
            // whole segment in one band
            pc_r    <= '{p_r[0], p_r[1], p_r[2], p_r[3], p_r[4], p_r[5], btop_r, 1'b1};
            state_r <= S_EMIT;
          end else begin
            state_r <= S_EDGE;
          end
        end

        S_EDGE: begin
          edge_r  <= 24'(top_y_r) - 24'(mul_p);
          axis_r  <= 1'b0;
          j_r     <= '0;
          state_r <= S_COEF;
        end

        S_COEF: begin
          a_r <= coef_a;
          b_r <= coef_b;
          c_r <= coef_c;
          s_r <= p_r[5] >= p_r[1];
          if (coef_a == '0) begin
            // straight in y: linear solve
            num_r <= lin_num;
            den_r <= lin_den;
            if (lin_den == '0) begin
              t_r     <= '0;
              state_r <= S_INTERP;
            end else begin
              state_r <= S_NORM;
            end
          end else begin
            state_r <= S_BB;
          end
        end

        S_BB: begin
          d_r     <= SQ_W'(mul_p);
          state_r <= S_AC;
        end

        S_AC: begin
          sq_v_r    <= disc_w[SQ_W-1] ? '0 : SQ_W'(disc_w);
          sq_root_r <= '0;
          sq_bit_r  <= SQ_W'(1) << (SQ_W - 2);
          cnt_r     <= 5'(SQ_STEPS);
          state_r   <= S_SQRT;
        end

        // one root bit per cycle
        S_SQRT: begin
          if (cnt_r == '0) begin
            num_r   <= DIV_N_W'(root_sum) <<< 16;
            den_r   <= 20'(a_r) <<< 1;
            state_r <= S_NORM;
          end else begin
            if (sq_v_r >= sq_try) begin
              sq_v_r    <= sq_v_r - sq_try;
              sq_root_r <= (sq_root_r >> 1) + sq_bit_r;
            end else begin
              sq_root_r <= sq_root_r >> 1;
            end
            sq_bit_r <= sq_bit_r >> 2;
            cnt_r    <= cnt_r - 5'd1;
          end
        end

        S_NORM: begin
          if (num_fix <= 0) begin
            t_r     <= '0;
            state_r <= S_INTERP;
          end else begin
            dv_band_r <= 1'b0;
            dv_den_r  <= dv_d;
            dv_rem_r  <= dv_hi[DIV_D_W-1:0];
            dv_low_r  <= dv_n[DIV_Q_W-1:0];
            // a quotient of 2^18 or more saturates at once
            dv_q_r    <= dv_sat ? '1 : '0;
            cnt_r     <= dv_sat ? 5'd0 : 5'(DIV_Q_W);
            state_r   <= S_DIV;
          end
        end

        // restoring divide, one quotient bit per cycle
        S_DIV: begin
          if (cnt_r == '0) begin
            if (dv_band_r) begin
              if (!band_sel_r) begin
                btop_r     <= band_q;
                band_sel_r <= 1'b1;
                state_r    <= S_BLOAD;
              end else begin
                bbot_r  <= band_q;
                state_r <= S_DECIDE;
              end
            end else begin
              t_r     <= (dv_q_r > DIV_Q_W'(T_ONE)) ? T_ONE : dv_q_r[T_W-1:0];
              state_r <= S_INTERP;
            end
          end else begin
            dv_rem_r <= dv_ge ? DIV_D_W'(dv_trial - {1'b0, dv_den_r}) : dv_trial[DIV_D_W-1:0];
            dv_q_r   <= {dv_q_r[DIV_Q_W-2:0], dv_ge};
            dv_low_r <= dv_low_r << 1;
            cnt_r    <= cnt_r - 5'd1;
          end
        end

        // de Casteljau per axis: q0, q1, then m
        S_INTERP: begin
          case (j_r)
            3'd0, 3'd2, 3'd4: acc_r <= mul_p;
            3'd1:             q0_r  <= 34'(acc_r + mul_p);
            3'd3:             q1_r  <= 34'(acc_r + mul_p);
            3'd5:             m_r   <= acc_r + mul_p;
            default: ;
          endcase
          if (j_r == 3'd6) begin
            if (!axis_r) begin
              pc_r.sx <= p_r[idx0];
              pc_r.cx <= rnd_q16(q0_r);
              pc_r.ex <= rnd_q32(m_r);
            end else begin
              pc_r.sy <= p_r[idx0];
              pc_r.cy <= rnd_q16(q0_r);
              pc_r.ey <= rnd_q32(m_r);
            end
            p_r[idx0] <= rnd_q32(m_r);
            p_r[idx1] <= rnd_q16(q1_r);
            j_r       <= '0;
            axis_r    <= 1'b1;
            if (axis_r) begin
              pc_r.band <= cur_band_r;
              pc_r.last <= 1'b0;
              state_r   <= S_EMIT;
            end
          end else begin
            j_r <= j_r + 3'd1;
          end
        end

        S_EMIT: begin
          if (out_load) begin
            if (pc_r.last) begin
              state_r <= S_IDLE;
            end else begin
              cur_band_r <= next_band;
              if (next_band == end_band_r) begin
                // what is left is the final piece
                pc_r    <= '{p_r[0], p_r[1], p_r[2], p_r[3], p_r[4], p_r[5], end_band_r, 1'b1};
              end else begin
                state_r <= S_EDGE;
              end
            end
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= pc_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.piece_start_x = out_r.sx;
  assign out_ch.piece_start_y = out_r.sy;
  assign out_ch.piece_ctrl_x  = out_r.cx;
  assign out_ch.piece_ctrl_y  = out_r.cy;
  assign out_ch.piece_end_x   = out_r.ex;
  assign out_ch.piece_end_y   = out_r.ey;
  assign out_ch.band_index    = out_r.band;
  assign out_ch.last_piece    = out_r.last;

endmodule
`default_nettype wire

[design/qbbs_checker.sv]
`default_nettype none
module qbbs_checker import qbbs_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_last,
  input logic [BAND_W-1:0] out_band,
  input coord_t            out_sx
);

  // an accepted segment keeps input ready low in the cycle after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accepting an item");

  // no new segment while a non-final piece of the current one is pending
  a_busy_mid_segment: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready while a segment is only partly delivered");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_band) && $stable(out_last)
      && $stable(out_sx))
    else $error("stalled output item changed");

endmodule

bind quadratic_bezier_band_splitter qbbs_checker u_qbbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last_piece),
  .out_band  (out_ch.band_index),
  .out_sx    (out_ch.piece_start_x)
);
`default_nettype wire

[tb/quadratic_bezier_band_splitter_tb.sv]
`timescale 1ns / 1ps
`default_nettype none
module quadratic_bezier_band_splitter_tb;
  import qbbs_pkg::*;

  localparam int IDLE_PCT   = 35;
  localparam int STALL_LIM  = 3000;  // longest quiet stretch: hold-off plus one cut
  localparam int HOLD_LEN   = 400;   // long receiver hold-off, in cycles

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    coord_t sx, sy, cx, cy, ex, ey;
  } segment_t;

  logic clk = 1'b0;
  logic rst_n;

  qbbs_cfg_if cfg_ch();
  qbbs_in_if  in_ch();
  qbbs_out_if out_ch();

  quadratic_bezier_band_splitter uut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_ch),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // shadow copy of the band registers, as the block holds them
  logic signed [15:0] band_top;
  logic [6:0]         band_num;
  logic [14:0]        band_hgt;

  piece_t expected_pieces[$];
  int     mismatches = 0;
  int     pieces_seen = 0;
  int     segments_sent = 0;
  int     split_segments = 0;
  int     max_split = 0;
  int     idle_pct = IDLE_PCT;
  int     stall_cycles = 0;
  bit     hold_req = 1'b0;

  function automatic void expect_piece(piece_t pc);
    expected_pieces.insert(expected_pieces.size(), pc);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: band lookup, edge solve for t, de Casteljau split
  // ---------------------------------------------------------------------------
  function automatic longint eff_count();
    if (band_num < 1) return 1;
    if (band_num > MAX_BANDS_DEF) return MAX_BANDS_DEF;
    return longint'(band_num);
  endfunction

  function automatic longint eff_height();
    return (band_hgt == 0) ? 1 : longint'(band_hgt);
  endfunction

  function automatic longint band_for_y(longint y);
    longint gap, h, q;
    gap = longint'(band_top) - y;
    h = eff_height();
    q = gap / h;
    // floor division for negative distances (above top_y)
    if ((gap % h) != 0 && gap < 0) q--;
    if (q < 0) q = 0;
    if (q > eff_count() - 1) q = eff_count() - 1;
    return q;
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // t in Q0.16 (65536 = 1.0) where the curve y reaches edge_y
  function automatic longint edge_t(longint y0, longint y1, longint y2, longint edge_y);
    longint a, b, c, disc, num, den, q, sgn;
    a = y0 - 2 * y1 + y2;
    if (a == 0) begin
      den = y2 - y0;
      if (den == 0) return 0;  // flat line: cut at the start
      num = (edge_y - y0) * 65536;
    end else begin
      b = 2 * (y1 - y0);
      c = y0 - edge_y;
      disc = b * b - 4 * a * c;
      sgn = (y2 - y0) >= 0 ? 1 : -1;
      if (disc < 0) disc = 0;  // no real root: treat as tangent
      num = (-b + sgn * floor_sqrt(longint'(disc))) * 65536;
      den = 2 * a;
    end
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (num <= 0) return 0;
    q = (num + den / 2) / den;
    return (q > 65536) ? 65536 : q;
  endfunction

  // round half away from zero, then drop sh fraction bits
  function automatic longint round_away(longint v, int sh);
    longint half;
    half = longint'(1) << (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -((-v + half) >>> sh);
  endfunction

  function automatic piece_t make_piece(longint p[6], longint band, bit last);
    piece_t pc;
    pc.sx = coord_t'(p[0]);
    pc.sy = coord_t'(p[1]);
    pc.cx = coord_t'(p[2]);
    pc.cy = coord_t'(p[3]);
    pc.ex = coord_t'(p[4]);
    pc.ey = coord_t'(p[5]);
    pc.band = band[BAND_W-1:0];
    pc.last = last;
    return pc;
  endfunction

  // cut rest at edge_y; the front piece goes out, rest keeps the tail
  task automatic cut_at_edge(inout longint rest[6], input longint edge_y, input longint band);
    longint front[6];
    longint t, u, q0, q1, m, mr;
    t = edge_t(rest[1], rest[3], rest[5], edge_y);
    u = 65536 - t;
    for (int i = 0; i < 2; i++) begin
      q0 = rest[i] * u + rest[2 + i] * t;
      q1 = rest[2 + i] * u + rest[4 + i] * t;
      m  = q0 * u + q1 * t;
      mr = round_away(m, 32);
      front[i]     = rest[i];
      front[2 + i] = round_away(q0, 16);
      front[4 + i] = mr;
      rest[i]      = mr;
      rest[2 + i]  = round_away(q1, 16);
    end
    expect_piece(make_piece(front, band, 1'b0));
  endtask

  task automatic predict_pieces(segment_t s);
    longint rest[6];
    longint b_hi, b_lo, h;
    rest = '{s.sx, s.sy, s.cx, s.cy, s.ex, s.ey};
    h = eff_height();
    b_hi = band_for_y(rest[1] > rest[5] ? rest[1] : rest[5]);
    b_lo = band_for_y(rest[1] < rest[5] ? rest[1] : rest[5]);
    if (b_hi == b_lo) begin
      expect_piece(make_piece(rest, b_hi, 1'b1));
      return;
    end
    split_segments++;
    if (b_lo - b_hi + 1 > max_split) max_split = int'(b_lo - b_hi + 1);
    if (rest[5] > rest[1]) begin
      // rising segment: walk bands upward from the start's band
      for (longint bd = b_lo; bd > b_hi; bd--)
        cut_at_edge(rest, longint'(band_top) - bd * h, bd);
      expect_piece(make_piece(rest, b_hi, 1'b1));
    end else begin
      for (longint bd = b_hi; bd < b_lo; bd++)
        cut_at_edge(rest, longint'(band_top) - (bd + 1) * h, bd);
      expect_piece(make_piece(rest, b_lo, 1'b1));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Reporting and watchdog
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, piece_t got, piece_t want);
    mismatches++;
    $display({"ERROR %0t %s: got %0d,%0d %0d,%0d %0d,%0d b%0d l%0d",
              " / want %0d,%0d %0d,%0d %0d,%0d b%0d l%0d"},
             $realtime, what, got.sx, got.sy, got.cx, got.cy, got.ex, got.ey, got.band,
             got.last, want.sx, want.sy, want.cx, want.cy, want.ex, want.ey, want.band,
             want.last);
  endtask

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIM) begin
      $display("ERROR: no handshake for %0d cycles, %0d pieces outstanding", STALL_LIM,
               expected_pieces.size());
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: check each accepted piece, then drive ready for the next edge
  // ---------------------------------------------------------------------------
  int hold_left = 0;

  always @(posedge clk) begin
    piece_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.sx = out_ch.piece_start_x;
        got.sy = out_ch.piece_start_y;
        got.cx = out_ch.piece_ctrl_x;
        got.cy = out_ch.piece_ctrl_y;
        got.ex = out_ch.piece_end_x;
        got.ey = out_ch.piece_end_y;
        got.band = out_ch.band_index;
        got.last = out_ch.last_piece;
        pieces_seen++;
        if (expected_pieces.size() == 0) begin
          report_mismatch("unexpected piece", got, got);
        end else begin
          want = expected_pieces.pop_front();
          if (got !== want) report_mismatch("piece differs", got, want);
        end
      end
      // long hold-off: the sender keeps offering so the block backs up
      if (hold_req && hold_left == 0) begin
        hold_req = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99, 0) >= idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input and configuration drivers
  // ---------------------------------------------------------------------------
  // the caller owns in_ch.valid between items: one assignment per edge
  task automatic send_segment(segment_t s, bit has_typed, piece_t typed);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.start_x <= s.sx;
    in_ch.start_y <= s.sy;
    in_ch.ctrl_x  <= s.cx;
    in_ch.ctrl_y  <= s.cy;
    in_ch.end_x   <= s.ex;
    in_ch.end_y   <= s.ey;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    segments_sent++;
    if (has_typed) expect_piece(typed);
    else predict_pieces(s);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_TOP_Y:       band_top = val;
      REG_BAND_COUNT:  band_num = val[6:0];
      REG_BAND_HEIGHT: band_hgt = val[14:0];
      default: ;  // unmapped index: block ignores it
    endcase
  endtask

  // wait for the block to drain before touching registers
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_pieces.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_bands(logic [15:0] top, logic [15:0] cnt, logic [15:0] hgt);
    drain();
    write_reg(REG_TOP_Y, top);
    write_reg(REG_BAND_COUNT, cnt);
    write_reg(REG_BAND_HEIGHT, hgt);
  endtask

  // y near the band span of the current setting, wrapped to 16 bits
  function automatic coord_t y_in_span(int extra);
    longint span;
    span = eff_count() * eff_height();
    return coord_t'(longint'(band_top) + eff_height() -
                    longint'($urandom_range(int'(span > 200000 ? 200000 : span) + extra, 0)));
  endfunction

  // mostly well-formed crossings; some full-range noise
  function automatic segment_t random_segment(int y_extra);
    segment_t s;
    s.sx = coord_t'($urandom);
    s.cx = coord_t'($urandom);
    s.ex = coord_t'($urandom);
    if ($urandom_range(9, 0) == 0) begin
      s.sy = coord_t'($urandom);
      s.cy = coord_t'($urandom);
      s.ey = coord_t'($urandom);
    end else begin
      s.sy = y_in_span(y_extra);
      s.ey = y_in_span(y_extra);
      case ($urandom_range(3, 0))
        0:       s.cy = coord_t'($urandom);
        1:       s.cy = s.sy;                        // control y at the start's y
        default: s.cy = y_in_span(y_extra);
      endcase
    end
    return s;
  endfunction

  task automatic random_run(int n, int y_extra);
    piece_t none;
    none = '0;
    repeat (n) send_segment(random_segment(y_extra), 1'b0, none);
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows: all run at the reset setting (one band), so every segment
  // comes back unchanged as a single last piece in band 0.
  // ---------------------------------------------------------------------------
  segment_t directed_rows[] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768},
    '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767},
    '{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767},
    '{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768},
    '{16'sd10, 16'sd0, 16'sd20, -16'sd100, 16'sd30, -16'sd300},
    '{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1},
    '{16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1},
    '{16'sd100, -16'sd74, 16'sd200, -16'sd75, 16'sd300, -16'sd76},
    '{16'sh5555, 16'sh2AAA, -16'sh5556, 16'sh5555, 16'sh2AAA, -16'sh5556},
    '{-16'sh5556, 16'sh5555, 16'sh2AAA, -16'sh5556, 16'sh5555, 16'sh2AAA},
    '{16'sd0, 16'sd75, 16'sd0, 16'sd0, 16'sd0, -16'sd75},
    '{16'sd0, 16'sd500, 16'sd0, -16'sd30000, 16'sd0, 16'sd500},
    '{16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd7}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    piece_t typed;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.start_x = '0;
    in_ch.start_y = '0;
    in_ch.ctrl_x = '0;
    in_ch.ctrl_y = '0;
    in_ch.end_x = '0;
    in_ch.end_y = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    band_top = TOP_Y_RST;
    band_num = BAND_COUNT_RST;
    band_hgt = BAND_HEIGHT_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      typed = {directed_rows[i], 6'd0, 1'b1};
      send_segment(directed_rows[i], 1'b1, typed);
    end

    // moderate bands
    set_bands(16'd500, 16'd8, 16'd100);
    random_run(60, 300);

    // top at the positive extreme, full 64 bands; no idling on either side
    set_bands(16'h7FFF, 16'd64, 16'd1024);
    idle_pct = 0;
    random_run(40, 2048);
    idle_pct = IDLE_PCT;

    // count 0 saturates to one band, height 0 acts as 1; stray register index
    set_bands(16'h8000, 16'd0, 16'd0);
    write_reg(REG_UNMAPPED, 16'hFFFF);
    random_run(20, 100);

    // count above the maximum, tallest bands
    set_bands(16'd0, 16'd127, 16'h7FFF);
    random_run(30, 40000);

    // one-unit bands: up to 63 cuts per segment
    set_bands(16'd2000, 16'd64, 16'd1);
    random_run(20, 10);

    // receiver stalls for a long stretch while segments keep coming
    set_bands(16'hFF9C, 16'd20, 16'd50);
    hold_req = 1'b1;
    random_run(70, 100);

    drain();
    $display("Sent %0d segments, %0d split across bands (up to %0d pieces each).",
             segments_sent, split_segments, max_split);
    $display("Checked %0d pieces over 7 band settings, %0d mismatches.",
             pieces_seen, mismatches);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
